// ===== rtl/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

	localparam logic [6:0] ASCII_ZERO  = 7'd48;
	localparam logic [6:0] ASCII_MINUS = 7'd45;
	localparam int         BCD_ADJ_MIN = 5;
	localparam int         BCD_ADJ_ADD = 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic skip;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic last_bit;
		logic top_zero;
		logic one_left;
		logic negative;
		logic slot_free;
	} status_t;

endpackage

// ===== rtl/itoa_ctrl.sv =====
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer: load, binary to BCD shifting, leading zero skip, then an optional
// sign and the digits, one character transfer per cycle while the output allows.
// ----------------------------------------------------------------------------
module itoa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  itoa_pkg::status_t  status,
	output itoa_pkg::cmd_t     cmd
);

	itoa_pkg::state_t state_q;
	itoa_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itoa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			itoa_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_d = itoa_pkg::ST_CONV;
				end
			end
			itoa_pkg::ST_CONV: begin
				if (status.last_bit) begin
					state_d = itoa_pkg::ST_SKIP;
				end
			end
			itoa_pkg::ST_SKIP: begin
				if (!(status.top_zero && !status.one_left)) begin
					state_d = status.negative ? itoa_pkg::ST_SIGN : itoa_pkg::ST_DIGIT;
				end
			end
			itoa_pkg::ST_SIGN: begin
				if (status.slot_free) begin
					state_d = itoa_pkg::ST_DIGIT;
				end
			end
			itoa_pkg::ST_DIGIT: begin
				if (status.slot_free && status.one_left) begin
					state_d = itoa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = itoa_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			itoa_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				cmd.load   = item_valid;
			end
			itoa_pkg::ST_CONV: begin
				cmd.step = 1'b1;
			end
			itoa_pkg::ST_SKIP: begin
				cmd.skip = status.top_zero && !status.one_left;
			end
			itoa_pkg::ST_SIGN: begin
				cmd.emit_sign = status.slot_free;
			end
			itoa_pkg::ST_DIGIT: begin
				cmd.emit_digit = status.slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/itoa_dp.sv =====
// ----------------------------------------------------------------------------
// itoa_dp
// Datapath: magnitude shift register, BCD register with add-3 correction,
// bit and digit counters, output character register.
// ----------------------------------------------------------------------------
module itoa_dp #(
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [VALUE_BITS-1:0] value,
	input  itoa_pkg::cmd_t               cmd,
	output itoa_pkg::status_t            status,
	output logic [6:0]                   char_code,
	output logic                         last,
	output logic                         char_valid,
	input  logic                         char_stall
);

	localparam int NDIG      = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BCD_W     = NDIG * 4;
	localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);
	localparam int DIG_CNT_W = $clog2(NDIG + 1);

	logic [VALUE_BITS-1:0] mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj;
	logic                  neg_q;
	logic [BIT_CNT_W-1:0]  bit_cnt_q;
	logic [DIG_CNT_W-1:0]  dig_cnt_q;
	logic [6:0]            char_q;
	logic                  last_q;
	logic                  valid_q;
	logic [3:0]            top_nib;
	logic                  raw_neg;

	assign raw_neg = value[VALUE_BITS-1];
	assign top_nib = bcd_q[BCD_W-1 -: 4];

	always_comb begin
		logic [3:0] nib;
		nib     = '0;
		bcd_adj = '0;
		for (int i = 0; i < NDIG; i++) begin
			nib = bcd_q[4*i +: 4];
			bcd_adj[4*i +: 4] = (nib >= 4'(itoa_pkg::BCD_ADJ_MIN)) ?
				nib + 4'(itoa_pkg::BCD_ADJ_ADD) : nib;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= raw_neg ? (~value + 1'b1) : value;
			neg_q <= raw_neg;
			bcd_q <= '0;
		end else if (cmd.step) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
		end else if (cmd.skip || cmd.emit_digit) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				bit_cnt_q <= BIT_CNT_W'(VALUE_BITS);
				dig_cnt_q <= DIG_CNT_W'(NDIG);
			end else begin
				if (cmd.step) begin
					bit_cnt_q <= bit_cnt_q - 1'b1;
				end
				if (cmd.skip || cmd.emit_digit) begin
					dig_cnt_q <= dig_cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			valid_q <= 1'b1;
		end else if (!char_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= itoa_pkg::ASCII_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= itoa_pkg::ASCII_ZERO + {3'd0, top_nib};
			last_q <= status.one_left;
		end
	end

	assign status.last_bit  = (bit_cnt_q == BIT_CNT_W'(1));
	assign status.top_zero  = (top_nib == 4'd0);
	assign status.one_left  = (dig_cnt_q == DIG_CNT_W'(1));
	assign status.negative  = neg_q;
	assign status.slot_free = !valid_q || !char_stall;

	assign char_code  = char_q;
	assign last       = last_q;
	assign char_valid = valid_q;

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a two's-complement integer to its decimal ASCII text, most
// significant character first, with a leading '-' for negative values.
// ----------------------------------------------------------------------------
// One value is converted at a time. After acceptance the magnitude is shifted
// into a BCD register one bit per cycle, leading zero digits are then dropped
// one per cycle, the skip state then selects the sign or the first digit,
// and the characters follow one per cycle as the output allows. The last
// character of each value is marked by last; the output register lets the
// next value be accepted while that character still waits for transfer.
module signed_int_to_decimal_ascii #(
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic                         item_valid,
	output logic                         item_stall,
	output logic [6:0]                   char_code,
	output logic                         last,
	output logic                         char_valid,
	input  logic                         char_stall
);

	itoa_pkg::cmd_t    cmd;
	itoa_pkg::status_t status;

	itoa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	itoa_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.cmd        (cmd),
		.status     (status),
		.char_code  (char_code),
		.last       (last),
		.char_valid (char_valid),
		.char_stall (char_stall)
	);

endmodule

// ===== test/signed_int_to_decimal_ascii_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// Sends signed 32-bit values through the converter and compares every
// character and last flag against decimal text predicted in the bench. The
// run starts with edge values, such as zero, the extremes, single digits and
// powers of ten. Random values of every length and sign follow, under three
// mixes of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;

	typedef struct packed {
		logic [6:0] code;
		logic       last;
	} text_char_t;

	class decimal_text_scoreboard;
		text_char_t pending_chars[$];
		int         mismatch_count = 0;

		function void note_value(logic signed [31:0] v);
			logic [31:0] mag;
			logic [3:0]  digit_buf [10];
			int          n;
			text_char_t  c;
			mag = v[31] ? (32'd0 - $unsigned(v)) : $unsigned(v);
			n = 0;
			do begin
				digit_buf[n] = 4'(mag % 32'd10);
				n++;
				mag = mag / 32'd10;
			end while (mag != 0);
			if (v[31]) begin
				c.code = itoa_pkg::ASCII_MINUS;
				c.last = 1'b0;
				pending_chars.push_back(c);
			end
			for (int i = n - 1; i >= 0; i--) begin
				c.code = itoa_pkg::ASCII_ZERO + 7'(digit_buf[i]);
				c.last = (i == 0);
				pending_chars.push_back(c);
			end
		endfunction

		function void check_char(logic [6:0] code, logic is_last);
			text_char_t want;
			if (pending_chars.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: char 0x%02h last %0b with nothing expected",
						$time, code, is_last);
				return;
			end
			want = pending_chars.pop_front();
			if (code !== want.code) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: char_code expected 0x%02h actual 0x%02h",
						$time, want.code, code);
			end
			if (is_last !== want.last) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: last expected %0b actual %0b",
						$time, want.last, is_last);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic signed [31:0] value = '0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic [6:0]         char_code;
	logic               last;
	logic               char_valid;
	logic               char_stall = 1'b0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	decimal_text_scoreboard text_sb;

	logic signed [31:0] directed_values [21] = '{
		32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
		32'sd100, -32'sd100, 32'sd2147483647, 32'h80000000, -32'sd2147483647,
		32'sd1000000000, -32'sd1000000000, 32'sd999999999, 32'sd123456789,
		-32'sd987654321, 32'h55555555, 32'hAAAAAAAA, 32'sd2147483646
	};

	signed_int_to_decimal_ascii uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.char_code  (char_code),
		.last       (last),
		.char_valid (char_valid),
		.char_stall (char_stall)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	always @(negedge clk) begin
		char_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && char_valid && !char_stall)
			text_sb.check_char(char_code, last);
	end

	task automatic send_value(input logic signed [31:0] v);
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		value      <= v;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		text_sb.note_value(v);
	endtask

	task automatic run_random(input int count);
		longint             lo;
		longint             hi;
		longint             mag;
		int                 digits;
		logic signed [31:0] v;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(3))
				0: v = $urandom;
				1: begin
					v = $urandom_range(20);
					if ($urandom_range(1))
						v = -v;
				end
				default: begin
					digits = $urandom_range(1, 10);
					lo = (digits == 1) ? 0 : 1;
					for (int d = 1; d < digits; d++)
						lo = lo * 10;
					hi = (digits == 1) ? 9 : lo * 10 - 1;
					if (hi > 64'sd2147483648)
						hi = 64'sd2147483648;
					mag = lo + longint'($urandom) % (hi - lo + 1);
					if (mag > 64'sd2147483647 || $urandom_range(1))
						v = 32'(-mag);
					else
						v = 32'(mag);
				end
			endcase
			send_value(v);
		end
	endtask

	initial begin
		text_sb = new;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct  = 22;
		recv_stall_pct = 61;
		foreach (directed_values[i])
			send_value(directed_values[i]);
		run_random(30);

		send_idle_pct  = 61;
		recv_stall_pct = 22;
		run_random(30);

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random(29);

		@(negedge clk);
		item_valid <= 1'b0;
		while (text_sb.pending_chars.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		if (text_sb.mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== signed_int_to_decimal_ascii.f =====
rtl/itoa_pkg.sv
rtl/itoa_ctrl.sv
rtl/itoa_dp.sv
rtl/signed_int_to_decimal_ascii.sv
test/signed_int_to_decimal_ascii_tb.sv
